### hdl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants for the line rasterizer: field widths, register map and
// operation codes.
// ----------------------------------------------------------------------------
package blr_pkg;

    // fixed payload widths
    localparam int COLOR_W    = 32;
    localparam int STRIDE_W   = 13;
    localparam int ADDR_W     = 24;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register indexes (word address bit 2)
    localparam logic REG_ROW_STRIDE = 1'b0;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1024;

    // operation codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

### hdl/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front
// Accepts input items, classifies them and performs the line setup for begin
// items: major axis, endpoint order, error term and increments.
// ----------------------------------------------------------------------------
module blr_front
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int CMD_W      = 6 * COORD_BITS + 43
) (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output logic [CMD_W-1:0]      o_q_data
);

    localparam int W = COORD_BITS;

    typedef struct packed {
        logic                 is_begin;
        logic [W-1:0]         major_start;
        logic [W-1:0]         major_end;
        logic [W-1:0]         minor_start;
        logic                 minor_down;
        logic                 steep;
        logic [W+1:0]         inc_straight;
        logic signed [W+2:0]  inc_diagonal;
        logic signed [W+2:0]  error_init;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

    logic [W-1:0]   w_dx, w_dy;
    logic           w_steep, w_swap;
    logic [W-1:0]   w_ms0, w_me0, w_ns0, w_ne0;
    logic [W-1:0]   w_ms, w_me, w_ns, w_ne;
    logic [W-1:0]   w_dmaj, w_dmin;
    logic [W+2:0]   w_dmaj_e, w_dmin_e;
    t_cmd           w_cmd;

    // absolute deltas and major axis (ties go to y)
    assign w_dx    = (i_x_end > i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign w_dy    = (i_y_end > i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
    assign w_steep = !(w_dy < w_dx);

    // map to major / minor coordinates
    assign w_ms0 = w_steep ? i_y_start : i_x_start;
    assign w_me0 = w_steep ? i_y_end   : i_x_end;
    assign w_ns0 = w_steep ? i_x_start : i_y_start;
    assign w_ne0 = w_steep ? i_x_end   : i_y_end;

    // order so the major coordinate rises
    assign w_swap = w_me0 < w_ms0;
    assign w_ms   = w_swap ? w_me0 : w_ms0;
    assign w_me   = w_swap ? w_ms0 : w_me0;
    assign w_ns   = w_swap ? w_ne0 : w_ns0;
    assign w_ne   = w_swap ? w_ns0 : w_ne0;

    assign w_dmaj   = w_me - w_ms;
    assign w_dmin   = (w_ne > w_ns) ? w_ne - w_ns : w_ns - w_ne;
    assign w_dmaj_e = (W+3)'(w_dmaj);
    assign w_dmin_e = (W+3)'(w_dmin);

    // queue entry
    always_comb begin
        w_cmd.is_begin     = (i_operation == OP_BEGIN);
        w_cmd.major_start  = w_ms;
        w_cmd.major_end    = w_me;
        w_cmd.minor_start  = w_ns;
        w_cmd.minor_down   = !(w_ne > w_ns);
        w_cmd.steep        = w_steep;
        w_cmd.inc_straight = {1'b0, w_dmin, 1'b0};
        w_cmd.inc_diagonal = $signed((w_dmin_e - w_dmaj_e) << 1);
        w_cmd.error_init   = $signed((w_dmin_e << 1) - w_dmaj_e);
        w_cmd.color        = i_color;
    end

    // transfer into the queue whenever it has room
    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;
    assign o_q_data = CMD_W'(w_cmd);

endmodule

### hdl/blr_queue.sv
// ----------------------------------------------------------------------------
// blr_queue
// Small register FIFO between setup and stepping, so each side stalls alone.
// ----------------------------------------------------------------------------
module blr_queue #(
    parameter int WIDTH = 115,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // fill count never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

### hdl/blr_back.sv
// ----------------------------------------------------------------------------
// blr_back
// Bresenham stepper: loads line setup from the queue, walks one pixel per
// step entry, and forms the linear address in a registered output stage.
// ----------------------------------------------------------------------------
module blr_back
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int CMD_W      = 6 * COORD_BITS + 43
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic [CMD_W-1:0]      i_q_data,
    output logic                  o_q_pop,
    input  logic [STRIDE_W-1:0]   i_row_stride,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_last_pixel
);

    localparam int W      = COORD_BITS;
    localparam int PROD_W = COORD_BITS + STRIDE_W;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    typedef struct packed {
        logic                 is_begin;
        logic [W-1:0]         major_start;
        logic [W-1:0]         major_end;
        logic [W-1:0]         minor_start;
        logic                 minor_down;
        logic                 steep;
        logic [W+1:0]         inc_straight;
        logic signed [W+2:0]  inc_diagonal;
        logic signed [W+2:0]  error_init;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

    t_cmd w_cmd;

    // line state
    logic                r_active;
    logic [W-1:0]        r_major_pos, r_major_end, r_minor_pos;
    logic signed [W+2:0] r_err;
    logic                r_minor_down, r_steep;
    logic [W+1:0]        r_inc_s;
    logic signed [W+2:0] r_inc_d;
    logic [COLOR_W-1:0]  r_color;

    // pixel stage
    logic                r_p1_valid;
    logic [W-1:0]        r_p1_x, r_p1_y;
    logic [COLOR_W-1:0]  r_p1_color;
    logic                r_p1_last;

    // output register
    logic                r_o_valid;
    logic [W-1:0]        r_o_x, r_o_y;
    logic [ADDR_W-1:0]   r_o_addr;
    logic [COLOR_W-1:0]  r_o_color;
    logic                r_o_last;

    logic                w_p2_ready, w_p1_ready, w_pop, w_emit, w_last, w_err_pos;
    logic [SUM_W-1:0]    w_addr_sum;
    logic                n_p1_valid, n_o_valid;

    assign w_cmd = t_cmd'(i_q_data);

    // stage handshakes
    assign w_p2_ready = !r_o_valid || !i_stall;
    assign w_p1_ready = !r_p1_valid || w_p2_ready;
    assign w_pop      = !i_q_empty && w_p1_ready;
    assign w_emit     = w_pop && !w_cmd.is_begin && r_active;
    assign o_q_pop    = w_pop;

    assign w_last    = (r_major_pos == r_major_end);
    assign w_err_pos = !r_err[W+2] && (r_err != '0);

    assign n_p1_valid = w_emit || (r_p1_valid && !w_p2_ready);
    assign n_o_valid  = (r_p1_valid && w_p2_ready) || (r_o_valid && i_stall);

    // linear address y * stride + x
    assign w_addr_sum = SUM_W'(r_p1_y) * SUM_W'(i_row_stride) + SUM_W'(r_p1_x);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_p1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_p1_valid <= n_p1_valid;
            r_o_valid  <= n_o_valid;
            if (w_pop && w_cmd.is_begin) begin
                r_active <= 1'b1;
            end else if (w_emit && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // line setup load and stepping
    always_ff @(posedge i_clk) begin
        if (w_pop && w_cmd.is_begin) begin
            r_major_pos  <= w_cmd.major_start;
            r_major_end  <= w_cmd.major_end;
            r_minor_pos  <= w_cmd.minor_start;
            r_minor_down <= w_cmd.minor_down;
            r_steep      <= w_cmd.steep;
            r_inc_s      <= w_cmd.inc_straight;
            r_inc_d      <= w_cmd.inc_diagonal;
            r_err        <= w_cmd.error_init;
            r_color      <= w_cmd.color;
        end else if (w_emit && !w_last) begin
            r_major_pos <= r_major_pos + 1'b1;
            if (w_err_pos) begin
                r_minor_pos <= r_minor_down ? r_minor_pos - 1'b1 : r_minor_pos + 1'b1;
                r_err       <= r_err + r_inc_d;
            end else begin
                r_err <= r_err + $signed({1'b0, r_inc_s});
            end
        end
    end

    // pixel stage payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_p1_x     <= r_steep ? r_minor_pos : r_major_pos;
            r_p1_y     <= r_steep ? r_major_pos : r_minor_pos;
            r_p1_color <= r_color;
            r_p1_last  <= w_last;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_p1_valid && w_p2_ready) begin
            r_o_x     <= r_p1_x;
            r_o_y     <= r_p1_y;
            r_o_addr  <= w_addr_sum[ADDR_W-1:0];
            r_o_color <= r_p1_color;
            r_o_last  <= r_p1_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pixel_x       = r_o_x;
    assign o_pixel_y       = r_o_y;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_last_pixel    = r_o_last;

    // the walk never passes the end point
    a_major_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_major_pos <= r_major_end))
        else $error("major position beyond line end");

    // the end point retires the line
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> !r_active)
        else $error("line still active after last pixel");

    // an output only appears from a filled pixel stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_p1_valid))
        else $error("output valid without pixel stage");

endmodule

### hdl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// All-octant Bresenham line stepper with linear address generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): operation begin loads two endpoints
//   and a color and emits nothing; operation step emits the next pixel of
//   the active line, or nothing when no line is active. A begin aborts any
//   line in progress.
//   Output channel (o_valid / i_stall): one transfer per pixel with x, y,
//   address y * row_stride + x (mod 2^24), color and a last flag on the
//   line's end point.
//   Throughput is one item per cycle while the output is not stalled. A
//   step transfer passes the queue, pixel stage and output register;
//   setup runs in the front, a four-entry queue sits between it and the
//   stepper, and the address multiply has its own output register stage.
//   Reset clears the queue, the pipeline valids and the active line, and
//   sets row_stride to 1024. When the receiver stalls, the output register
//   holds, the pixel stage and the queue fill, and o_stall rises once the
//   queue is full.
//   row_stride is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_W-1:0]    i_color,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_last_pixel,
    // configuration port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int CMD_W   = 6 * COORD_BITS + 43;
    localparam int Q_DEPTH = 4;

    logic [STRIDE_W-1:0] r_row_stride;
    logic                w_cfg_wr;
    logic                w_q_full, w_q_empty, w_q_push, w_q_pop;
    logic [CMD_W-1:0]    w_q_in, w_q_head;

    // configuration register
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_stride <= STRIDE_RESET;
        end else if (w_cfg_wr && (i_paddr[2] == REG_ROW_STRIDE)) begin
            r_row_stride <= i_pwdata[STRIDE_W-1:0];
        end
    end

    // register readback
    assign o_prdata = (i_paddr[2] == REG_ROW_STRIDE) ? APB_DATA_W'(r_row_stride) : '0;

    // setup front
    blr_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_color     (i_color),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in)
    );

    // decoupling queue
    blr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_data (w_q_in),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_empty     (w_q_empty),
        .o_head      (w_q_head)
    );

    // stepper back end
    blr_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_q_head),
        .o_q_pop         (w_q_pop),
        .i_row_stride    (r_row_stride),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
